// ===== design/llsd_pkg.sv =====
// ----------------------------------------------------------------------------
// llsd_pkg: shared types and constants for the leader-lag signal detector
// Register indexes, field widths, sequencer states.
// ----------------------------------------------------------------------------
package llsd_pkg;

  localparam int unsigned HistoryDepthDefault = 100;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] RegOwnTicker  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLeadTicker = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinCorr    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMoveMin    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLagMin     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLookback   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMinFill    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare      = 3'd7;  // no register behind it

  typedef struct packed {
    logic        cmd;
    logic [15:0] ticker_id;
    logic [47:0] timestamp_ms;
    logic [31:0] mid_price;
    logic signed [15:0] correlation;
    logic [15:0] confidence;
  } llsd_in_t;

  typedef struct packed {
    logic [47:0] signal_time;
    logic [31:0] signal_price;
    logic signed [31:0] ldr_move;
    logic signed [31:0] own_move;
    logic signed [31:0] predicted_move;
    logic signed [31:0] lag_difference;
    logic signed [15:0] correlation_out;
    logic [15:0] confidence_out;
  } llsd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CUR_RD, ST_CUR_WT, ST_SCAN_RD, ST_SCAN_WT, ST_OLD_RD,
    ST_OLD_WT, ST_DIV, ST_NEXT, ST_MUL, ST_SAT, ST_DONE
  } llsd_state_e;

endpackage

// ===== design/llsd_if.sv =====
// ----------------------------------------------------------------------------
// llsd_if: valid/ready channel carrying one payload
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
interface llsd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/leader_lag_signal_detector_unit.sv =====
// ----------------------------------------------------------------------------
// leader_lag_signal_detector_unit: leader-lag signal detector
// Two ring histories in memories, one sequencer, one shared divider.
// ----------------------------------------------------------------------------
// Flow: a leader or foreign request is taken while the sequencer stays in
// ST_IDLE; an own request stopped by the fill or correlation gate holds the
// input through ST_NEXT. An evaluating own frame walks each held history one
// entry at a time and after each walk runs a 55-step restoring divide (skipped
// for a zero reference price). A waiting signal blocks the input until taken.
// Reset clears heads, counts, registers and output valid; memories unreset.
module leader_lag_signal_detector_unit #(
  parameter int unsigned HISTORY_DEPTH = llsd_pkg::HistoryDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  llsd_if.sink                          in_i,
  llsd_if.source                        out_o,
  input  logic                          cfg_we_i,
  input  logic [llsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [llsd_pkg::CfgDataW-1:0] cfg_data_i
);
  import llsd_pkg::*;

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned DW = 55;        // |cur-ref|*6553600 < 2^55
  localparam logic [AW-1:0] LastIdx = AW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(HISTORY_DEPTH);

  // configuration registers
  logic [15:0] own_tick_q, lead_tick_q, min_corr_q, lookback_q;
  logic [30:0] move_min_q, lag_min_q;
  logic [6:0]  min_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_tick_q <= 16'd0;     lead_tick_q <= 16'd1;
      min_corr_q <= 16'd22938; move_min_q  <= 31'd32768;
      lag_min_q  <= 31'd19661; lookback_q  <= 16'd5000;
      min_fill_q <= 7'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOwnTicker:  own_tick_q  <= cfg_data_i[15:0];
        RegLeadTicker: lead_tick_q <= cfg_data_i[15:0];
        RegMinCorr:    min_corr_q  <= cfg_data_i[15:0];
        RegMoveMin:    move_min_q  <= cfg_data_i;
        RegLagMin:     lag_min_q   <= cfg_data_i;
        RegLookback:   lookback_q  <= cfg_data_i[15:0];
        RegMinFill:    min_fill_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // history memories: own_* hold the own ticker, ld_* the leader
  logic [47:0] own_t_mem [HISTORY_DEPTH];
  logic [31:0] own_p_mem [HISTORY_DEPTH];
  logic [47:0] ld_t_mem  [HISTORY_DEPTH];
  logic [31:0] ld_p_mem  [HISTORY_DEPTH];
  logic [AW-1:0] own_head_q, ld_head_q;
  logic [CW-1:0] own_cnt_q, ld_cnt_q;

  llsd_state_e state_q, state_d;
  llsd_in_t    item_q;
  logic        hsel_q, hsel_d;            // 0 leader, 1 own
  logic [AW-1:0] raddr_q, raddr_d;
  logic [CW-1:0] left_q, left_d;
  logic [47:0] rd_t_q;
  logic [31:0] rd_p_q;
  logic [31:0] cur_q, cur_d, ref_q, ref_d;
  logic [5:0]  step_q, step_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic signed [31:0] lmove_q, lmove_d, omove_q, omove_d;
  logic signed [47:0] prod_q, prod_d;
  logic        in_rdy, push, own_push, ld_push;
  llsd_out_t   out_q, out_d;
  logic        ov_q, ov_d;

  assign in_rdy    = (state_q == ST_IDLE) && !ov_q;
  assign in_i.ready = in_rdy;
  assign push      = in_i.valid && in_rdy;
  assign own_push  = push && !in_i.data.cmd && in_i.data.ticker_id == own_tick_q;
  assign ld_push   = push && in_i.data.cmd && in_i.data.ticker_id == lead_tick_q;
  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i) begin
    if (own_push) begin
      own_t_mem[own_head_q] <= in_i.data.timestamp_ms;
      own_p_mem[own_head_q] <= in_i.data.mid_price;
    end
    if (ld_push) begin
      ld_t_mem[ld_head_q] <= in_i.data.timestamp_ms;
      ld_p_mem[ld_head_q] <= in_i.data.mid_price;
    end
    if (hsel_q) begin
      rd_t_q <= own_t_mem[raddr_q];
      rd_p_q <= own_p_mem[raddr_q];
    end else begin
      rd_t_q <= ld_t_mem[raddr_q];
      rd_p_q <= ld_p_mem[raddr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_head_q <= '0; own_cnt_q <= '0; ld_head_q <= '0; ld_cnt_q <= '0;
    end else begin
      if (own_push) begin
        own_head_q <= (own_head_q == LastIdx) ? '0 : own_head_q + 1'b1;
        if (own_cnt_q != DepthC) own_cnt_q <= own_cnt_q + 1'b1;
      end
      if (ld_push) begin
        ld_head_q <= (ld_head_q == LastIdx) ? '0 : ld_head_q + 1'b1;
        if (ld_cnt_q != DepthC) ld_cnt_q <= ld_cnt_q + 1'b1;
      end
    end
  end

  // sequencer helpers
  logic [AW-1:0] head_sel, newest, oldest, dec_addr;
  logic [CW-1:0] cnt_sel;
  logic [AW:0]   old_sum;
  logic signed [48:0] age;
  logic [32:0]   rem_sh;
  logic [31:0]   diff_mag;
  logic [31:0]   q_mag;
  logic signed [32:0] q_s;
  logic signed [47:0] e_t;
  logic signed [31:0] e_sat;
  logic signed [32:0] lag_w;
  logic signed [31:0] lag_sat;
  logic [31:0]   lm_abs, lag_abs;
  logic [15:0]   corr_abs;
  logic          corr_neg;

  assign head_sel = hsel_q ? own_head_q : ld_head_q;
  assign cnt_sel  = hsel_q ? own_cnt_q : ld_cnt_q;
  assign newest   = (head_sel == '0) ? LastIdx : head_sel - 1'b1;
  assign old_sum  = {1'b0, head_sel} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(cnt_sel);
  assign oldest   = (old_sum >= (AW+1)'(HISTORY_DEPTH))
                  ? AW'(old_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(old_sum);
  assign dec_addr = (raddr_q == '0) ? LastIdx : raddr_q - 1'b1;
  assign age      = $signed({1'b0, item_q.timestamp_ms}) - $signed({1'b0, rd_t_q});
  assign rem_sh   = {rem_q[31:0], dvd_q[DW-1]};
  assign diff_mag = (cur_q >= ref_q) ? cur_q - ref_q : ref_q - cur_q;
  assign q_mag    = (dvd_q[DW-1:32] != '0) ? 32'hFFFF_FFFF : dvd_q[31:0];
  assign corr_neg = item_q.correlation[15];
  assign corr_abs = corr_neg ? 16'(-item_q.correlation) : item_q.correlation;
  assign e_t      = prod_q[47] ? -((-prod_q) >>> 15) : (prod_q >>> 15);
  assign e_sat    = (e_t > 48'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                    (e_t < -48'sh8000_0000) ? 32'sh8000_0000 : e_t[31:0];
  assign lag_w    = 33'(e_sat) - 33'(omove_q);
  assign lag_sat  = (lag_w > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                    (lag_w < -33'sh0_8000_0000) ? 32'sh8000_0000 : lag_w[31:0];
  assign lm_abs   = lmove_q[31] ? 32'(-lmove_q) : lmove_q;
  assign lag_abs  = lag_sat[31] ? 32'(-lag_sat) : lag_sat;

  always_comb begin
    state_d = state_q; hsel_d = hsel_q; raddr_d = raddr_q; left_d = left_q;
    cur_d = cur_q; ref_d = ref_q; step_d = step_q;
    dvd_d = dvd_q; rem_d = rem_q; neg_d = neg_q; lmove_d = lmove_q;
    omove_d = omove_q; prod_d = prod_q; out_d = out_q; ov_d = ov_q;
    q_s = '0;
    if (ov_q && out_o.ready) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (own_push) state_d = ST_NEXT;
      // ST_NEXT on entry: check gates, start leader history (own if leader is empty)
      ST_NEXT: begin
        if (32'(ld_cnt_q) < 32'(min_fill_q) || 32'(own_cnt_q) < 32'(min_fill_q) ||
            {1'b0, corr_abs} < {1'b0, min_corr_q}) state_d = ST_IDLE;
        else begin
          hsel_d = 1'b0; state_d = ST_CUR_RD;
          if (ld_cnt_q == '0) begin lmove_d = '0; hsel_d = 1'b1; end
        end
      end
      ST_CUR_RD: begin raddr_d = newest; state_d = ST_CUR_WT; end
      ST_CUR_WT: state_d = ST_SCAN_RD;
      ST_SCAN_RD: begin
        cur_d = rd_p_q; left_d = cnt_sel; ref_d = '0;
        state_d = ST_SCAN_WT;
      end
      ST_SCAN_WT: begin
        // rd_* holds entry raddr_q
        if (age >= $signed({33'd0, lookback_q})) begin
          ref_d = rd_p_q; state_d = ST_OLD_RD;
        end else if (left_q == CW'(1)) state_d = ST_OLD_RD;
        else begin
          left_d = left_q - 1'b1; raddr_d = dec_addr; state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_SCAN_WT;  // wait for read data
      end
      ST_OLD_RD: begin
        if (ref_q == '0) begin raddr_d = oldest; state_d = ST_OLD_WT; end
        else state_d = ST_DIV;
        step_d = 6'd0;
      end
      ST_OLD_WT: begin
        if (step_q == 6'd0) step_d = 6'd1;
        else begin ref_d = rd_p_q; step_d = 6'd0; state_d = ST_DIV; end
      end
      ST_DIV: begin
        if (step_q == 6'd0) begin
          neg_d = cur_q < ref_q;
          dvd_d = {23'd0, diff_mag} * 55'd6553600;
          rem_d = '0; step_d = 6'd1;
          if (ref_q == '0) step_d = 6'(DW + 1);
        end else if (step_q <= 6'(DW)) begin
          if (rem_sh >= {1'b0, ref_q}) begin
            rem_d = rem_sh - {1'b0, ref_q}; dvd_d = {dvd_q[DW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh; dvd_d = {dvd_q[DW-2:0], 1'b0};
          end
          step_d = step_q + 1'b1;
        end else begin
          if (ref_q == '0) q_s = '0;
          else if (neg_q) q_s = (q_mag > 32'h8000_0000) ? -33'sh0_8000_0000
                                                      : -$signed({1'b0, q_mag});
          else q_s = (q_mag > 32'h7FFF_FFFF) ? 33'sh0_7FFF_FFFF
                                             : $signed({1'b0, q_mag});
          step_d = '0;
          if (!hsel_q) begin
            lmove_d = q_s[31:0]; hsel_d = 1'b1; state_d = ST_CUR_RD;
          end else begin
            omove_d = q_s[31:0]; state_d = ST_SAT;
          end
        end
      end
      ST_SAT: begin
        prod_d = 48'(lmove_q) * 48'(item_q.correlation);
        if ({1'b0, lm_abs} < {2'b0, move_min_q} ||
            !((lmove_q[31] == corr_neg) || item_q.correlation == '0))
          state_d = ST_IDLE;
        else state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
        if ({1'b0, lag_abs} >= {2'b0, lag_min_q}) begin
          out_d.signal_time = item_q.timestamp_ms;
          out_d.signal_price = item_q.mid_price;
          out_d.ldr_move = lmove_q; out_d.own_move = omove_q;
          out_d.predicted_move = e_sat; out_d.lag_difference = lag_sat;
          out_d.correlation_out = item_q.correlation;
          out_d.confidence_out = item_q.confidence;
          ov_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // empty-leader bypass: ST_CUR_RD with hsel already own handles it
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ov_q <= 1'b0; step_q <= '0; hsel_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; step_q <= step_d; hsel_q <= hsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) item_q <= in_i.data;
    raddr_q <= raddr_d; left_q <= left_d; cur_q <= cur_d; ref_q <= ref_d;
    dvd_q <= dvd_d; rem_q <= rem_d; neg_q <= neg_d;
    lmove_q <= lmove_d; omove_q <= omove_d; prod_q <= prod_d; out_q <= out_d;
  end

endmodule

// ===== test/llsd_checker.sv =====
// ----------------------------------------------------------------------------
// llsd_checker: scoreboard for the leader-lag signal detector
// Watches config writes and both channels, predicts each signal, compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llsd_checker
  import llsd_pkg::*;
#(
  parameter int unsigned Depth = HistoryDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  llsd_if                     in_ch,
  llsd_if                     out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  signals_due_o
);

  localparam int DueSlots = 16;

  logic [15:0] own_tick, lead_tick, min_corr, lookback;
  logic [30:0] move_min, lag_min;
  logic [6:0]  min_fill;

  // hist index 0 = own, 1 = leader
  logic [47:0] h_time [2][Depth];
  logic [31:0] h_price[2][Depth];
  int unsigned h_head[2], h_count[2];

  // predicted signals, ring of slots with running write and read counts
  llsd_out_t due_sig [DueSlots];
  int        due_wr, due_rd;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void hist_push(int s, logic [47:0] t, logic [31:0] p);
    h_time[s][h_head[s]]  = t;
    h_price[s][h_head[s]] = p;
    h_head[s] = (h_head[s] + 1) % Depth;
    if (h_count[s] < Depth) h_count[s]++;
  endfunction

  // percent move over the lookback, Q16.16
  function automatic longint pct_move(int s, logic [47:0] now);
    int unsigned newest, oldest, k;
    longint cur, base, age;
    base = 0;
    if (h_count[s] == 0) return 0;
    newest = (h_head[s] + Depth - 1) % Depth;
    oldest = (h_head[s] + Depth - h_count[s]) % Depth;
    cur = longint'(h_price[s][newest]);
    for (int i = 0; i < h_count[s]; i++) begin
      k = (newest + Depth - i) % Depth;
      age = longint'({16'd0, now}) - longint'({16'd0, h_time[s][k]});
      if (age >= longint'(lookback)) begin
        base = longint'(h_price[s][k]);
        break;
      end
    end
    if (base == 0) base = longint'(h_price[s][oldest]);
    if (base == 0) return 0;
    return clamp32((cur - base) * 100 * 65536 / base);
  endfunction

  function automatic void predict_frame(llsd_in_t f);
    longint corr, lmv, omv, expv, lag;
    llsd_out_t sig;
    corr = longint'(f.correlation);
    if (f.cmd) begin
      if (f.ticker_id == lead_tick) hist_push(1, f.timestamp_ms, f.mid_price);
      return;
    end
    if (f.ticker_id != own_tick) return;
    hist_push(0, f.timestamp_ms, f.mid_price);
    if (h_count[1] < min_fill || h_count[0] < min_fill) return;
    if (absval(corr) < longint'(min_corr)) return;
    lmv = pct_move(1, f.timestamp_ms);
    omv = pct_move(0, f.timestamp_ms);
    if (absval(lmv) < longint'(move_min)) return;
    if (!(((lmv < 0) == (corr < 0)) || corr == 0)) return;
    expv = lmv * corr;
    expv = (expv < 0) ? -((-expv) >>> 15) : (expv >>> 15);
    expv = clamp32(expv);
    lag = clamp32(expv - omv);
    if (absval(lag) < longint'(lag_min)) return;
    sig.signal_time     = f.timestamp_ms;
    sig.signal_price    = f.mid_price;
    sig.ldr_move        = 32'(lmv);
    sig.own_move        = 32'(omv);
    sig.predicted_move  = 32'(expv);
    sig.lag_difference  = 32'(lag);
    sig.correlation_out = f.correlation;
    sig.confidence_out  = f.confidence;
    due_sig[due_wr % DueSlots] = sig;
    due_wr++;
  endfunction

  function automatic void check_signal(llsd_out_t got);
    llsd_out_t exp_sig;
    if (due_wr == due_rd) begin
      mismatches_o++;
      if (mismatches_o <= 10) $display("unexpected signal: %p", got);
      return;
    end
    exp_sig = due_sig[due_rd % DueSlots];
    due_rd++;
    if (got.signal_time     !== exp_sig.signal_time    ||
        got.signal_price    !== exp_sig.signal_price   ||
        got.ldr_move        !== exp_sig.ldr_move       ||
        got.own_move        !== exp_sig.own_move       ||
        got.predicted_move  !== exp_sig.predicted_move ||
        got.lag_difference  !== exp_sig.lag_difference ||
        got.correlation_out !== exp_sig.correlation_out ||
        got.confidence_out  !== exp_sig.confidence_out) begin
      mismatches_o++;
      if (mismatches_o <= 10) begin
        $display("signal mismatch at %0t", $realtime);
        $display("  expected %p", exp_sig);
        $display("  actual   %p", got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_tick  <= 16'd0;
      lead_tick <= 16'd1;
      min_corr  <= 16'd22938;
      move_min  <= 31'd32768;
      lag_min   <= 31'd19661;
      lookback  <= 16'd5000;
      min_fill  <= 7'd50;
      h_head       = '{0, 0};
      h_count      = '{0, 0};
      due_wr       = 0;
      due_rd       = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegOwnTicker:  own_tick  <= cfg_data_i[15:0];
          RegLeadTicker: lead_tick <= cfg_data_i[15:0];
          RegMinCorr:    min_corr  <= cfg_data_i[15:0];
          RegMoveMin:    move_min  <= cfg_data_i;
          RegLagMin:     lag_min   <= cfg_data_i;
          RegLookback:   lookback  <= cfg_data_i[15:0];
          RegMinFill:    min_fill  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_frame(in_ch.data);
      if (out_ch.valid && out_ch.ready) check_signal(out_ch.data);
    end
  end

  assign signals_due_o = due_wr - due_rd;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the leader-lag signal detector
// Drives price frames and register settings, varies idling on both channels,
// and leaves prediction and comparison to llsd_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import llsd_pkg::*;

  localparam int SettlePause = 600;    // covers the longest own-frame evaluation
  localparam int StallLimit  = 20000;  // cycles without any request moving

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  mismatches;
  int                  signals_due;

  llsd_if #(.T(llsd_in_t))  in_if ();
  llsd_if #(.T(llsd_out_t)) out_if ();

  leader_lag_signal_detector_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  llsd_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .signals_due_o (signals_due)
  );

  // idling percentages of the current phase
  int send_gap_pct;
  int recv_stall_pct;

  // tickers and stream state of the current phase
  logic [15:0] own_tick, lead_tick;
  logic [47:0] now_ms;
  logic [31:0] own_px, lead_px;
  int          step_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: stalls at random per phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: any accepted request on either channel restarts the count
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // one request; valid stays high when the next one follows without a gap
  task automatic send_frame(llsd_in_t f);
    if ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= f;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (signals_due != 0) @(posedge clk_i);
    repeat (SettlePause) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] own, logic [15:0] lead, logic [15:0] mc,
                          logic [30:0] mm, logic [30:0] lm, logic [15:0] lb,
                          logic [6:0] mf);
    write_reg(RegOwnTicker, 31'(own));
    write_reg(RegLeadTicker, 31'(lead));
    write_reg(RegMinCorr, 31'(mc));
    write_reg(RegMoveMin, mm);
    write_reg(RegLagMin, lm);
    write_reg(RegLookback, 31'(lb));
    write_reg(RegMinFill, 31'(mf));
    own_tick  = own;
    lead_tick = lead;
  endtask

  function automatic llsd_in_t frame(logic c, logic [15:0] tk, logic [47:0] ts,
                                     logic [31:0] px, logic [15:0] corr,
                                     logic [15:0] conf);
    llsd_in_t f;
    f.cmd = c; f.ticker_id = tk; f.timestamp_ms = ts; f.mid_price = px;
    f.correlation = corr; f.confidence = conf;
    return f;
  endfunction

  // price walk with jumps of up to about 25%, occasionally to zero, the top or a small random price
  function automatic logic [31:0] walk(logic [31:0] px);
    longint v;
    int r;
    r = $urandom_range(99);
    if (r < 2) return 32'd0;
    if (r < 4) return 32'hFFFF_FFFF;
    if (r < 7) return $urandom_range(2000, 1);
    v = longint'(px) + 1;
    v = v + (v * longint'(int'($urandom_range(500)) - 250)) / 1000;
    if (v < 1) v = 1;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return 32'(v);
  endfunction

  function automatic logic [15:0] rand_corr();
    if ($urandom_range(9) < 7) begin
      return $urandom_range(1) ? 16'($urandom_range(32767, 16000))
                               : 16'(-$urandom_range(32768, 16000));
    end
    return 16'($urandom);
  endfunction

  // mostly well-formed streams on the two configured tickers, some noise
  task automatic random_stream(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      now_ms += $urandom_range(step_ms);
      if (r < 45) begin
        own_px = walk(own_px);
        send_frame(frame(1'b0, own_tick, now_ms, own_px, rand_corr(),
                         16'($urandom)));
      end else if (r < 90) begin
        lead_px = walk(lead_px);
        send_frame(frame(1'b1, lead_tick, now_ms, lead_px, 16'($urandom),
                         16'($urandom)));
      end else if (r < 95) begin
        // foreign ticker on a well-formed stream
        send_frame(frame(1'($urandom), own_tick ^ lead_tick ^ 16'($urandom_range(9, 1)),
                         now_ms, $urandom, $urandom, $urandom));
      end else begin
        // fully random noise, timestamps anywhere
        send_frame(frame(1'($urandom), 16'($urandom),
                         {16'($urandom), 32'($urandom)}, $urandom,
                         16'($urandom), 16'($urandom)));
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    in_if.valid    <= 1'b0;
    in_if.data     <= '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: low thresholds so that nearly every own frame signals
    set_regs(16'd7, 16'd9, 16'd0, 31'd0, 31'd0, 16'd1000, 7'd2);
    write_reg(RegSpare, 31'h7FFF_FFFF);  // unused index, ignored
    send_frame(frame(1'b0, 16'd7, 48'd0, 32'd100, 16'sd0, 16'd0));          // no leader yet
    send_frame(frame(1'b1, 16'd9, 48'd0, 32'd0, 16'sd0, 16'd0));            // zero price
    send_frame(frame(1'b1, 16'd9, 48'd500, 32'd1000, 16'sd0, 16'd0));
    send_frame(frame(1'b1, 16'd8, 48'd600, 32'd5, 16'sd0, 16'd0));          // foreign
    send_frame(frame(1'b0, 16'd9, 48'd700, 32'd5, 16'sd0, 16'd0));          // foreign
    send_frame(frame(1'b0, 16'd7, 48'd1500, 32'd150, 16'sh7FFF, 16'hFFFF));
    send_frame(frame(1'b0, 16'd7, 48'd1600, 32'd50, 16'sh8000, 16'd1));
    send_frame(frame(1'b0, 16'd7, 48'd1700, 32'd0, 16'sd0, 16'd2));
    send_frame(frame(1'b1, 16'd9, 48'd1800, 32'hFFFF_FFFF, 16'sd0, 16'd0));
    send_frame(frame(1'b0, 16'd7, 48'd3000, 32'hFFFF_FFFF, 16'sh8000, 16'hFFFF));
    send_frame(frame(1'b0, 16'd7, 48'd3100, 32'd1, 16'sh7FFF, 16'h8000));
    send_frame(frame(1'b1, 16'd9, 48'd3200, 32'd1, 16'sd0, 16'd0));
    send_frame(frame(1'b0, 16'd7, 48'd4500, 32'd3, 16'shC000, 16'd5));
    send_frame(frame(1'b0, 16'd7, 48'd4600, 32'd3, 16'sh4000, 16'd6));
    send_frame(frame(1'b0, 16'd7, 48'hFFFF_FFFF_FFFF, 32'd9, 16'sh7FFF, 16'd7));
    send_frame(frame(1'b1, 16'd9, 48'hFFFF_FFFF_FFFF, 32'd7, 16'sd0, 16'd0));
    send_frame(frame(1'b0, 16'd7, 48'd10, 32'd2, 16'shFFFF, 16'd8));      // time goes back
    send_frame(frame(1'b0, 16'd7, 48'd20, 32'd2, 16'sd1, 16'd9));
    go_idle();

    // random phases: tickers, thresholds and idling vary, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 52; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 52; end
        default: begin send_gap_pct = 27; recv_stall_pct = 27; end
      endcase
      case (ph)
        0: set_regs(16'd0, 16'hFFFF, 16'd0, 31'd0, 31'd0, 16'd1, 7'd1);
        1: set_regs(16'hFFFF, 16'd0, 16'd32768, 31'd65536, 31'd1000, 16'd65535,
                    7'd3);
        2: set_regs(16'd1, 16'd0, 16'd22938, 31'd32768, 31'd19661, 16'd5000,
                    7'd50);
        3: set_regs(16'd4, 16'd5, 16'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd2000,
                    7'd100);
        4: set_regs(16'd4, 16'd5, 16'd0, 31'd0, 31'd0, 16'd3000, 7'd127);
        default: set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(26000)),
                          31'($urandom_range(1 << 20)), 31'($urandom_range(1 << 20)),
                          16'($urandom_range(8000, 1)), 7'($urandom_range(12, 1)));
      endcase
      now_ms  = {16'd0, 32'($urandom)};
      own_px  = $urandom_range(100000, 10);
      lead_px = $urandom_range(100000, 10);
      step_ms = (ph == 1) ? 40000 : 2500;
      random_stream(ph == 2 ? 150 : 230);
      go_idle();
    end

    if (mismatches == 0 && signals_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/llsd_pkg.sv
design/llsd_if.sv
design/leader_lag_signal_detector_unit.sv
test/llsd_checker.sv
test/testbench.sv
